// ----- sv/rbd_pkg.sv -----
package rbd_pkg;

  localparam int unsigned DEPTH      = 64;
  localparam int unsigned DATA_WIDTH = 32;
  localparam int unsigned AW         = $clog2(DEPTH);
  localparam int unsigned CW         = $clog2(DEPTH + 1);

  localparam logic [2:0] CMD_ADD_BACK  = 3'd0;
  localparam logic [2:0] CMD_ADD_FRONT = 3'd1;
  localparam logic [2:0] CMD_REM_BACK  = 3'd2;
  localparam logic [2:0] CMD_REM_FRONT = 3'd3;
  localparam logic [2:0] CMD_READ      = 3'd4;
  localparam logic [2:0] CMD_CLEAR     = 3'd5;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;
  localparam logic [1:0] ST_RANGE = 2'd3;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [31:0] value;
    logic [5:0]  position;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] read_data;
    logic [6:0]  fill_count;
  } out_word_t;

  typedef struct packed {
    logic exec;
    logic resp;
  } rbd_ctrl_t;

  typedef struct packed {
    logic full;
    logic empty;
  } rbd_stat_t;

  function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] head,
                                            input logic [CW-1:0] offs);
    logic [CW:0] sum;
    sum = {{(CW + 1 - AW){1'b0}}, head} + {1'b0, offs};
    if (sum >= (CW + 1)'(DEPTH)) begin
      sum = sum - (CW + 1)'(DEPTH);
    end
    return sum[AW-1:0];
  endfunction

endpackage

// ----- sv/rbd_ctrl.sv -----
module rbd_ctrl
  import rbd_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  rbd_stat_t stat,
  output rbd_ctrl_t ctrl,
  output logic      busy,
  output logic      out_valid
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_RESP = 1'b1;

  logic state_r;
  logic state_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt = S_RESP;
        end
      end
      S_RESP: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign ctrl.exec = (state_r == S_IDLE) && start;
  assign ctrl.resp = (state_r == S_RESP);
  assign busy      = ctrl.resp;
  assign out_valid = ctrl.resp;

  a_exec_then_resp: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.exec |=> ctrl.resp) else $error("exec not followed by response");
  a_resp_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.resp |-> $past(ctrl.exec)) else $error("response without exec");
  a_full_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !(stat.full && stat.empty)) else $error("queue both full and empty");

endmodule

// ----- sv/rbd_dp.sv -----
module rbd_dp
  import rbd_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  rbd_ctrl_t ctrl,
  input  in_word_t  in_word,
  output rbd_stat_t stat,
  output out_word_t out_word
);

  logic [DATA_WIDTH-1:0] mem [DEPTH];
  logic [DATA_WIDTH-1:0] rd_q_r;

  logic [AW-1:0] head_r;
  logic [AW-1:0] head_nxt;
  logic [CW-1:0] count_r;
  logic [CW-1:0] count_nxt;
  logic [1:0]    status_r;
  logic [1:0]    status_nxt;
  logic          rd_ok_r;
  logic          rd_ok_nxt;

  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] head_dec;
  logic [CW-1:0] pos_ext;

  assign stat.full  = (count_r == CW'(DEPTH));
  assign stat.empty = (count_r == '0);
  assign head_dec   = (head_r == '0) ? AW'(DEPTH - 1) : head_r - AW'(1);
  assign pos_ext    = CW'(in_word.position);

  always_comb begin
    head_nxt   = head_r;
    count_nxt  = count_r;
    status_nxt = ST_OK;
    rd_ok_nxt  = 1'b0;
    wr_en      = 1'b0;
    wr_addr    = slot_of(head_r, count_r);
    rd_en      = 1'b0;
    rd_addr    = slot_of(head_r, pos_ext);
    case (in_word.cmd)
      CMD_ADD_BACK: begin
        if (stat.full) begin
          status_nxt = ST_FULL;
        end else begin
          wr_en     = 1'b1;
          count_nxt = count_r + CW'(1);
        end
      end
      CMD_ADD_FRONT: begin
        if (stat.full) begin
          status_nxt = ST_FULL;
        end else begin
          wr_en     = 1'b1;
          wr_addr   = head_dec;
          head_nxt  = head_dec;
          count_nxt = count_r + CW'(1);
        end
      end
      CMD_REM_BACK: begin
        if (stat.empty) begin
          status_nxt = ST_EMPTY;
        end else begin
          count_nxt = count_r - CW'(1);
        end
      end
      CMD_REM_FRONT: begin
        if (stat.empty) begin
          status_nxt = ST_EMPTY;
        end else begin
          head_nxt  = slot_of(head_r, CW'(1));
          count_nxt = count_r - CW'(1);
        end
      end
      CMD_READ: begin
        if (pos_ext >= count_r) begin
          status_nxt = ST_RANGE;
        end else begin
          rd_en     = 1'b1;
          rd_ok_nxt = 1'b1;
        end
      end
      CMD_CLEAR: begin
        if (stat.empty) begin
          status_nxt = ST_EMPTY;
        end else begin
          head_nxt  = '0;
          count_nxt = '0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctrl.exec && wr_en) begin
      mem[wr_addr] <= in_word.value[DATA_WIDTH-1:0];
    end
    if (ctrl.exec && rd_en) begin
      rd_q_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r   <= '0;
      count_r  <= '0;
      status_r <= ST_OK;
      rd_ok_r  <= 1'b0;
    end else if (ctrl.exec) begin
      head_r   <= head_nxt;
      count_r  <= count_nxt;
      status_r <= status_nxt;
      rd_ok_r  <= rd_ok_nxt;
    end
  end

  assign out_word.status     = status_r;
  assign out_word.read_data  = rd_ok_r ? 32'(rd_q_r) : '0;
  assign out_word.fill_count = 7'(count_r);

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH)) else $error("fill count beyond capacity");
  a_idle_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !$past(ctrl.exec) |-> $stable(count_r) && $stable(head_r))
    else $error("state moved without a command");

endmodule

// ----- sv/ring_buffer_deque_core.sv -----
// Double-ended queue of 64 words of 32 bits in a circular store.
// Input: raise start with in_word (cmd, value, position); the word is taken
// at a rising edge with start high and busy low.
// Output: one result word per command on out_word, shown for exactly one
// cycle with out_valid high: status, read_data and the fill count after
// the command. read_data is zero except for a successful read.
// Timing: the result appears in the cycle after acceptance; busy is high
// during that cycle, so no new command is taken while a result is shown.
// The delay is set by the registered read port of the entry store.
// Reset (rst_n low, synchronous): the queue is emptied, head slot set to 0,
// no result pending. Store contents are not cleared; only written entries
// are ever read.
// The receiver cannot stall: each result must be taken in its cycle.
module ring_buffer_deque_core
  import rbd_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_word_t  in_word,
  output logic      out_valid,
  output out_word_t out_word
);

  rbd_ctrl_t ctrl;
  rbd_stat_t stat;

  rbd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .stat      (stat),
    .ctrl      (ctrl),
    .busy      (busy),
    .out_valid (out_valid)
  );

  rbd_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl     (ctrl),
    .in_word  (in_word),
    .stat     (stat),
    .out_word (out_word)
  );

endmodule

// ----- verif/tb_ring_buffer_deque_core.sv -----
module tb_ring_buffer_deque_core
  import rbd_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] CMD_SPARE_6 = 3'd6;
  localparam logic [2:0] CMD_SPARE_7 = 3'd7;
  localparam int CYCLE_LIMIT = 200000;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      start = 1'b0;
  in_word_t  in_word = '0;
  logic      busy;
  logic      out_valid;
  out_word_t out_word;

  logic [DATA_WIDTH-1:0] shadow_store [DEPTH];
  int unsigned           shadow_head;
  int unsigned           shadow_count;

  out_word_t awaited_results [$];
  out_word_t want;
  int        errors;
  int        cycles;
  int        burst_left;

  ring_buffer_deque_core dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_word  (in_word),
    .out_valid(out_valid),
    .out_word (out_word)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic out_word_t apply_command(in_word_t w);
    out_word_t r;
    r = '0;
    r.status = ST_OK;
    case (w.cmd)
      CMD_ADD_BACK: begin
        if (shadow_count >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          shadow_store[(shadow_head + shadow_count) % DEPTH] = w.value;
          shadow_count++;
        end
      end
      CMD_ADD_FRONT: begin
        if (shadow_count >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          shadow_head = (shadow_head + DEPTH - 1) % DEPTH;
          shadow_store[shadow_head] = w.value;
          shadow_count++;
        end
      end
      CMD_REM_BACK: begin
        if (shadow_count == 0) r.status = ST_EMPTY;
        else shadow_count--;
      end
      CMD_REM_FRONT: begin
        if (shadow_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          shadow_head = (shadow_head + 1) % DEPTH;
          shadow_count--;
        end
      end
      CMD_READ: begin
        if (w.position >= shadow_count) r.status = ST_RANGE;
        else r.read_data = shadow_store[(shadow_head + w.position) % DEPTH];
      end
      CMD_CLEAR: begin
        if (shadow_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          shadow_count = 0;
          shadow_head = 0;
        end
      end
      default: ;
    endcase
    r.fill_count = shadow_count[6:0];
    return r;
  endfunction

  // hold start high across back-to-back words; drop it only for a gap
  task automatic send_word(logic [2:0] op, logic [31:0] data, logic [5:0] idx);
    in_word_t w;
    w.cmd = op;
    w.value = data;
    w.position = idx;
    start <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (busy);
    awaited_results.push_back(apply_command(w));
    burst_left--;
    if (burst_left <= 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 90)
                                               : $urandom_range(1, 20);
    end
  endtask

  task automatic report(string field, logic [31:0] exp_v, logic [31:0] got_v);
    $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, field, exp_v, got_v);
    errors++;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (awaited_results.size() == 0) begin
        $display("%0t ns: unexpected result word, expected none, got %0h", $time, out_word);
        errors++;
      end else begin
        want = awaited_results.pop_front();
        if (out_word.status !== want.status)
          report("status", 32'(want.status), 32'(out_word.status));
        if (out_word.read_data !== want.read_data)
          report("read_data", want.read_data, out_word.read_data);
        if (out_word.fill_count !== want.fill_count)
          report("fill_count", 32'(want.fill_count), 32'(out_word.fill_count));
      end
    end
  end

  function automatic logic [5:0] pick_index();
    if (shadow_count > 0 && $urandom_range(0, 99) < 85)
      return 6'($urandom_range(0, shadow_count - 1));
    return 6'($urandom_range(0, 63));
  endfunction

  function automatic logic [31:0] pick_data();
    case ($urandom_range(0, 15))
      0: return 32'h0;
      1: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  task automatic test_empty_and_edges();
    send_word(CMD_REM_BACK, 32'h0, 6'd0);
    send_word(CMD_REM_FRONT, 32'hFFFF_FFFF, 6'd63);
    send_word(CMD_CLEAR, 32'h0, 6'd0);
    send_word(CMD_READ, 32'h0, 6'd0);
    send_word(CMD_READ, 32'h0, 6'd63);
    send_word(CMD_ADD_BACK, 32'h0, 6'd0);
    send_word(CMD_ADD_BACK, 32'hFFFF_FFFF, 6'd63);
    send_word(CMD_ADD_FRONT, 32'hA5A5_5A5A, 6'd0);
    send_word(CMD_READ, 32'h0, 6'd0);
    send_word(CMD_READ, 32'h0, 6'd1);
    send_word(CMD_READ, 32'h0, 6'd2);
    send_word(CMD_READ, 32'h0, 6'd3);
    send_word(CMD_READ, 32'h0, 6'd63);
    send_word(CMD_SPARE_6, 32'hFFFF_FFFF, 6'd63);
    send_word(CMD_SPARE_7, 32'h1234_5678, 6'd1);
    send_word(CMD_REM_BACK, 32'h0, 6'd0);
    send_word(CMD_REM_FRONT, 32'h0, 6'd0);
    send_word(CMD_READ, 32'h0, 6'd0);
    send_word(CMD_CLEAR, 32'h0, 6'd0);
    send_word(CMD_READ, 32'h0, 6'd0);
    send_word(CMD_ADD_FRONT, 32'h8000_0001, 6'd0);
    send_word(CMD_REM_BACK, 32'h0, 6'd0);
    send_word(CMD_REM_BACK, 32'h0, 6'd0);
  endtask

  task automatic test_fill_and_drain();
    for (int pass = 0; pass < 2; pass++) begin
      while (shadow_count < DEPTH)
        send_word($urandom_range(0, 1) ? CMD_ADD_FRONT : CMD_ADD_BACK, pick_data(), 6'd0);
      send_word(CMD_ADD_BACK, $urandom, 6'($urandom_range(0, 63)));
      send_word(CMD_ADD_FRONT, $urandom, 6'($urandom_range(0, 63)));
      send_word(CMD_READ, 32'h0, 6'd63);
      send_word(CMD_READ, 32'h0, 6'd0);
      repeat (6) send_word(CMD_READ, $urandom, 6'($urandom_range(0, 63)));
      while (shadow_count > 0)
        send_word($urandom_range(0, 1) ? CMD_REM_FRONT : CMD_REM_BACK, $urandom, pick_index());
      send_word(CMD_REM_FRONT, $urandom, 6'($urandom_range(0, 63)));
    end
  endtask

  task automatic test_random_mix(int count);
    int add_pct;
    int rem_pct;
    int r;
    add_pct = 35;
    rem_pct = 30;
    for (int n = 0; n < count; n++) begin
      if (n % 60 == 0) begin
        case ($urandom_range(0, 2))
          0: begin add_pct = 55; rem_pct = 15; end
          1: begin add_pct = 35; rem_pct = 30; end
          default: begin add_pct = 15; rem_pct = 55; end
        endcase
      end
      r = $urandom_range(0, 99);
      if (r < 1)
        send_word(CMD_CLEAR, $urandom, 6'($urandom_range(0, 63)));
      else if (r < 3)
        send_word($urandom_range(0, 1) ? CMD_SPARE_6 : CMD_SPARE_7, $urandom,
                  6'($urandom_range(0, 63)));
      else if (r < 3 + add_pct)
        send_word($urandom_range(0, 1) ? CMD_ADD_FRONT : CMD_ADD_BACK, pick_data(),
                  6'($urandom_range(0, 63)));
      else if (r < 3 + add_pct + rem_pct)
        send_word($urandom_range(0, 1) ? CMD_REM_FRONT : CMD_REM_BACK, $urandom,
                  6'($urandom_range(0, 63)));
      else
        send_word(CMD_READ, $urandom, pick_index());
    end
  endtask

  initial begin
    errors = 0;
    cycles = 0;
    shadow_head = 0;
    shadow_count = 0;
    burst_left = $urandom_range(1, 20);
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    test_empty_and_edges();
    test_fill_and_drain();
    test_random_mix(560);
    start <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (errors == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule
